### rtl/lin_master_frame_engine_assert.svh
// Assertion macros of the LIN master frame engine core (lmfe_core).
`ifndef LIN_MASTER_FRAME_ENGINE_ASSERT_SVH
`define LIN_MASTER_FRAME_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LMFE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmfe: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define LMFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmfe: next-cycle check failed");

`endif

### rtl/lmfe_pkg.sv
// Types, codes and helper functions of the LIN master frame engine.
`default_nettype none

package lmfe_pkg;

  localparam int unsigned MAX_BYTES_DEF = 8;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] AGE_MAX       = 16'hFFFF;
  localparam logic [7:0]  BREAK_BYTE    = 8'h00;
  localparam logic [7:0]  SYNC_BYTE     = 8'h55;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_START  = 2'd1,
    REQ_RXBYTE = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_BUSY     = 2'd2,
    ST_TOO_LONG = 2'd3
  } start_status_t;

  typedef enum logic [1:0] {
    DONE_NONE     = 2'd0,
    DONE_SENT     = 2'd1,
    DONE_RECEIVED = 2'd2,
    DONE_ERROR    = 2'd3
  } frame_done_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  frame_id;
    logic [3:0]  frame_len;
    logic        send_mode;
    logic        enhanced;
    logic [63:0] payload;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  start_status;
    logic        send_break;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  frame_done;
    logic [5:0]  rx_frame_id;
    logic [3:0]  rx_frame_len;
    logic [63:0] rx_payload;
  } out_item_t;

  // Protected identifier: id plus two parity bits.
  function automatic logic [7:0] make_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Add with end-around carry (sum above 0xFF folds back by 0xFF).
  function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > 9'd255) begin
      s = s - 9'd255;
    end
    return s[7:0];
  endfunction

endpackage

`default_nettype wire

### rtl/lmfe_if.sv
// Channel interfaces of the LIN master frame engine: request, response, config.
`default_nettype none

interface lmfe_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  frame_id;
  logic [3:0]  frame_len;
  logic        send_mode;
  logic        enhanced;
  logic [63:0] payload;
  logic [7:0]  rx_byte;

  modport source (
    output valid, req_type, frame_id, frame_len, send_mode, enhanced, payload, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, frame_id, frame_len, send_mode, enhanced, payload, rx_byte,
    output ready
  );
endinterface

interface lmfe_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  start_status;
  logic        send_break;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic [1:0]  frame_done;
  logic [5:0]  rx_frame_id;
  logic [3:0]  rx_frame_len;
  logic [63:0] rx_payload;

  modport source (
    output valid, start_status, send_break, tx_valid, tx_byte, frame_done,
           rx_frame_id, rx_frame_len, rx_payload,
    input  ready
  );
  modport sink (
    input  valid, start_status, send_break, tx_valid, tx_byte, frame_done,
           rx_frame_id, rx_frame_len, rx_payload,
    output ready
  );
endinterface

interface lmfe_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/lin_master_frame_engine.sv
// Top level of the LIN master frame engine.
//
//   channel  dir  carries                                       handshake
//   req      in   request item: tick, start or bus byte         valid/ready
//   rsp      out  result item: status, tx byte, frame done      valid/ready
//   cfg      in   frame_timeout, 16 bit                         valid/ready
//
// Each item passes the request register, then one pass through the frame state
// machine into the result register, whose output drives rsp.valid and the reply.
// Throughput is one item per cycle while rsp is not stalled; each data byte is a
// single end-around-carry add. rst (synchronous) clears phase, counters and
// checksum and reloads frame_timeout with 1000; the data buffer is not cleared.
// A stalled rsp holds the result register; req.ready drops only when both
// registers are full. cfg.ready stays high.
`default_nettype none

module lin_master_frame_engine #(
  parameter int unsigned MAX_BYTES = lmfe_pkg::MAX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lmfe_req_if.sink   req,
  lmfe_rsp_if.source rsp,
  lmfe_cfg_if.sink   cfg
);

  lmfe_pkg::in_item_t  req_item;
  lmfe_pkg::in_item_t  core_item;
  lmfe_pkg::out_item_t core_res;
  lmfe_pkg::out_item_t rsp_item;

  logic core_valid;
  logic core_ready;
  logic res_valid;
  logic res_ready;

  always_comb begin
    req_item.req_type  = req.req_type;
    req_item.frame_id  = req.frame_id;
    req_item.frame_len = req.frame_len;
    req_item.send_mode = req.send_mode;
    req_item.enhanced  = req.enhanced;
    req_item.payload   = req.payload;
    req_item.rx_byte   = req.rx_byte;
  end

  // request register
  lmfe_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_item   (req_item),
    .out_valid (core_valid),
    .out_ready (core_ready),
    .out_item  (core_item)
  );

  // frame state machine; consumes an item when the result register has room
  lmfe_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (core_valid),
    .item_ready (core_ready),
    .item       (core_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (core_res),
    .cfg_valid  (cfg.valid),
    .cfg_data   (cfg.data)
  );

  // writes belong in idle periods
  assign cfg.ready = 1'b1;

  // result register
  lmfe_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_item   (core_res),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_item  (rsp_item)
  );

  assign rsp.start_status = rsp_item.start_status;
  assign rsp.send_break   = rsp_item.send_break;
  assign rsp.tx_valid     = rsp_item.tx_valid;
  assign rsp.tx_byte      = rsp_item.tx_byte;
  assign rsp.frame_done   = rsp_item.frame_done;
  assign rsp.rx_frame_id  = rsp_item.rx_frame_id;
  assign rsp.rx_frame_len = rsp_item.rx_frame_len;
  assign rsp.rx_payload   = rsp_item.rx_payload;

endmodule

`default_nettype wire

### rtl/lmfe_in_stage.sv
// Input register stage of the LIN master frame engine.
`default_nettype none

module lmfe_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lmfe_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output lmfe_pkg::in_item_t out_item
);

  logic               held_valid;
  lmfe_pkg::in_item_t held_item;

  assign in_ready  = !held_valid || out_ready;
  assign out_valid = held_valid;
  assign out_item  = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (out_ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

### rtl/lmfe_core.sv
// Frame state machine, data buffer and running checksum of the LIN master.
`default_nettype none

module lmfe_core #(
  parameter int unsigned MAX_BYTES = lmfe_pkg::MAX_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  lmfe_pkg::in_item_t  item,
  output logic                res_valid,
  input  logic                res_ready,
  output lmfe_pkg::out_item_t res,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_data
);

  `include "lin_master_frame_engine_assert.svh"

  localparam int unsigned IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [3:0]  MAX4  = 4'(MAX_BYTES);

  typedef enum logic [2:0] {
    PH_IDLE           = 3'd0,
    PH_BREAK          = 3'd1,
    PH_SYNC           = 3'd2,
    PH_PID            = 3'd3,
    PH_DATA           = 3'd4,
    PH_CHECKSUM       = 3'd5,
    PH_CHECKSUM_AFTER = 3'd6
  } phase_t;

  // state
  phase_t      phase;
  logic        publish_mode;
  logic        enhanced_sum;
  logic [5:0]  frame_ident;
  logic [7:0]  protected_id;
  logic [7:0]  data_buffer [MAX_BYTES];
  logic [3:0]  byte_count;
  logic [3:0]  byte_index;
  logic [7:0]  sent_checksum;
  logic [7:0]  sum_acc;       // running end-around-carry sum
  logic [15:0] frame_age;
  logic [15:0] frame_timeout;

  phase_t      phase_next;
  logic [3:0]  byte_index_next;
  logic [7:0]  sent_checksum_next;
  logic [7:0]  sum_acc_next;
  logic [15:0] frame_age_next;
  logic        load_frame;
  logic        store_rx;

  logic        fire;
  logic        err;
  logic [7:0]  pid_new;
  logic [7:0]  cur_byte;
  logic [7:0]  chk;
  logic [3:0]  idx_inc;
  logic [63:0] rx_bytes;

  assign fire       = item_valid && res_ready;
  assign item_ready = res_ready;
  assign res_valid  = item_valid;

  assign pid_new = lmfe_pkg::make_pid(item.frame_id);
  assign chk     = ~sum_acc;
  assign idx_inc = byte_index + 4'd1;

  always_comb begin
    cur_byte = data_buffer[0];
    if (byte_index < MAX4) begin
      cur_byte = data_buffer[byte_index[IDX_W-1:0]];
    end
  end

  // Stored bytes of the current frame, unused upper bytes zero.
  always_comb begin
    rx_bytes = '0;
    for (int i = 0; i < MAX_BYTES; i++) begin
      if (4'(i) < byte_count) begin
        rx_bytes[8*i +: 8] = data_buffer[i];
      end
    end
  end

  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    sent_checksum_next = sent_checksum;
    sum_acc_next       = sum_acc;
    frame_age_next     = frame_age;
    load_frame         = 1'b0;
    store_rx           = 1'b0;
    err                = 1'b0;
    res                = '0;

    if (fire) begin
      case (item.req_type)
        lmfe_pkg::REQ_TICK: begin
          if (phase != PH_IDLE && frame_age != lmfe_pkg::AGE_MAX) begin
            frame_age_next = frame_age + 16'd1;
          end
        end
        lmfe_pkg::REQ_START: begin
          if (item.frame_len > MAX4) begin
            res.start_status = lmfe_pkg::ST_TOO_LONG;
          end else if (phase != PH_IDLE && frame_age < frame_timeout) begin
            res.start_status = lmfe_pkg::ST_BUSY;
          end else begin
            load_frame       = 1'b1;
            phase_next       = PH_BREAK;
            byte_index_next  = '0;
            frame_age_next   = '0;
            sum_acc_next     = item.enhanced ? pid_new : 8'h00;
            res.start_status = lmfe_pkg::ST_ACCEPTED;
            res.send_break   = 1'b1;
          end
        end
        lmfe_pkg::REQ_RXBYTE: begin
          case (phase)
            PH_BREAK: begin
              if (item.rx_byte == lmfe_pkg::BREAK_BYTE) begin
                res.tx_valid = 1'b1;
                res.tx_byte  = lmfe_pkg::SYNC_BYTE;
                phase_next   = PH_SYNC;
              end else begin
                err = 1'b1;
              end
            end
            PH_SYNC: begin
              if (item.rx_byte == lmfe_pkg::SYNC_BYTE) begin
                res.tx_valid    = 1'b1;
                res.tx_byte     = protected_id;
                byte_index_next = '0;
                phase_next      = PH_PID;
              end else begin
                err = 1'b1;
              end
            end
            PH_PID: begin
              if (item.rx_byte != protected_id) begin
                err = 1'b1;
              end else begin
                byte_index_next = '0;
                if (byte_count == 4'd0) begin
                  if (publish_mode) begin
                    sent_checksum_next = chk;
                    res.tx_valid       = 1'b1;
                    res.tx_byte        = chk;
                    phase_next         = PH_CHECKSUM_AFTER;
                  end else begin
                    phase_next = PH_CHECKSUM;
                  end
                end else if (publish_mode) begin
                  res.tx_valid    = 1'b1;
                  res.tx_byte     = data_buffer[0];
                  sum_acc_next    = lmfe_pkg::eac_add(sum_acc, data_buffer[0]);
                  byte_index_next = 4'd1;
                  phase_next      = (byte_count <= 4'd1) ? PH_CHECKSUM : PH_DATA;
                end else begin
                  phase_next = PH_DATA;
                end
              end
            end
            PH_DATA: begin
              if (byte_index >= MAX4 || byte_index >= byte_count) begin
                phase_next = PH_CHECKSUM;
              end else begin
                if (publish_mode) begin
                  res.tx_valid = 1'b1;
                  res.tx_byte  = cur_byte;
                  sum_acc_next = lmfe_pkg::eac_add(sum_acc, cur_byte);
                end else begin
                  store_rx     = 1'b1;
                  sum_acc_next = lmfe_pkg::eac_add(sum_acc, item.rx_byte);
                end
                byte_index_next = idx_inc;
                if (idx_inc >= byte_count) begin
                  phase_next = PH_CHECKSUM;
                end
              end
            end
            PH_CHECKSUM: begin
              sent_checksum_next = chk;
              if (publish_mode) begin
                res.tx_valid = 1'b1;
                res.tx_byte  = chk;
                phase_next   = PH_CHECKSUM_AFTER;
              end else if (item.rx_byte == chk) begin
                res.frame_done   = lmfe_pkg::DONE_RECEIVED;
                res.rx_frame_id  = frame_ident;
                res.rx_frame_len = byte_count;
                res.rx_payload   = rx_bytes;
                phase_next       = PH_IDLE;
              end else begin
                err = 1'b1;
              end
            end
            PH_CHECKSUM_AFTER: begin
              if (item.rx_byte == sent_checksum) begin
                res.frame_done = lmfe_pkg::DONE_SENT;
                phase_next     = PH_IDLE;
              end else begin
                err = 1'b1;
              end
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
          if (err) begin
            res.frame_done = lmfe_pkg::DONE_ERROR;
            phase_next     = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      publish_mode  <= 1'b0;
      enhanced_sum  <= 1'b0;
      frame_ident   <= '0;
      protected_id  <= '0;
      byte_count    <= '0;
      byte_index    <= '0;
      sent_checksum <= '0;
      sum_acc       <= '0;
      frame_age     <= '0;
      frame_timeout <= lmfe_pkg::TIMEOUT_RESET;
    end else begin
      if (cfg_valid) begin
        frame_timeout <= cfg_data;
      end
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      sent_checksum <= sent_checksum_next;
      sum_acc       <= sum_acc_next;
      frame_age     <= frame_age_next;
      if (load_frame) begin
        frame_ident  <= item.frame_id;
        protected_id <= pid_new;
        byte_count   <= item.frame_len;
        publish_mode <= item.send_mode;
        enhanced_sum <= item.enhanced;
        for (int i = 0; i < MAX_BYTES; i++) begin
          if (item.send_mode && 4'(i) < item.frame_len) begin
            data_buffer[i] <= item.payload[8*i +: 8];
          end
        end
      end
      if (store_rx) begin
        data_buffer[byte_index[IDX_W-1:0]] <= item.rx_byte;
      end
    end
  end

  // enhanced_sum only seeds the running sum; keep it observable for checks.
  `LMFE_ASSERT_NOW(a_enh_seed,
    phase == PH_BREAK && !enhanced_sum, sum_acc == 8'h00)
  `LMFE_ASSERT_NEXT(a_start_arms,
    fire && res.start_status == lmfe_pkg::ST_ACCEPTED,
    phase == PH_BREAK && frame_age == 16'd0 && byte_index == 4'd0)
  `LMFE_ASSERT_NOW(a_index_bound,
    phase != PH_IDLE, byte_index <= byte_count && byte_count <= MAX4)
  `LMFE_ASSERT_NEXT(a_done_idle,
    fire && res.frame_done != lmfe_pkg::DONE_NONE, phase == PH_IDLE)
  `LMFE_ASSERT_NOW(a_done_quiet,
    res.frame_done != lmfe_pkg::DONE_NONE, !res.tx_valid && !res.send_break)

endmodule

`default_nettype wire

### rtl/lmfe_out_stage.sv
// Result register stage of the LIN master frame engine.
`default_nettype none

module lmfe_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lmfe_pkg::out_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output lmfe_pkg::out_item_t out_item
);

  logic                q_valid;
  lmfe_pkg::out_item_t q_item;

  assign in_ready  = !q_valid || out_ready;
  assign out_valid = q_valid;
  assign out_item  = q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (out_ready) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_item <= in_item;
    end
  end

endmodule

`default_nettype wire

### dv/tb_lin_master_frame_engine.sv
// Self-checking testbench for the LIN master frame engine: driver, monitor and frame predictor.
module tb_lin_master_frame_engine;
  import lmfe_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 150;
  localparam int RANDOM_ITEMS = 225;

  typedef enum logic [2:0] {
    FR_IDLE, FR_BREAK, FR_SYNC, FR_PID, FR_DATA, FR_CHECKSUM, FR_CHECKSUM_ECHO
  } frame_phase_t;

  logic clk = 1'b0;
  logic rst;

  lmfe_req_if req_bus();
  lmfe_rsp_if rsp_bus();
  lmfe_cfg_if cfg_bus();

  lin_master_frame_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state, mirrors the engine's frame registers.
  frame_phase_t fr_phase;
  logic        fr_publish;
  logic        fr_enh;
  logic [5:0]  fr_id;
  logic [7:0]  fr_pid;
  logic [63:0] fr_data;
  logic [3:0]  fr_len;
  logic [3:0]  fr_idx;
  logic [7:0]  fr_chk;
  logic [15:0] fr_age;
  logic [15:0] fr_timeout;

  in_item_t  pending_items[$];
  out_item_t expected_replies[$];

  in_item_t  next_req;
  in_item_t  seen_req;
  out_item_t seen_rsp;
  out_item_t want_rsp;

  bit req_taken;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_asks;
  int hold_seen;
  int hold_left;
  int timeout_now;

  int issued_count;
  int checked_count;
  int mismatches;
  int cycle_count;
  int n_sent, n_recv, n_err, n_accept, n_refused, n_in_stalls;

  // PID: id with parity bits P0 (ids 0,1,2,4) and inverted P1 (ids 1,3,4,5).
  function automatic logic [7:0] pid_of(input logic [5:0] id);
    return {~^(id & 6'b111010), ^(id & 6'b010111), id};
  endfunction

  // Inverted sum with end-around carry over the first n bytes, seeded.
  function automatic logic [7:0] checksum_of(input logic [7:0] seed, input logic [63:0] bytes,
                                             input int n);
    logic [8:0] acc;
    int i;
    acc = {1'b0, seed};
    for (i = 0; i < n && i < MAX_BYTES_DEF; i++) begin
      acc = acc + {1'b0, bytes[8*i +: 8]};
      if (acc[8]) begin
        acc = {1'b0, acc[7:0]} + 9'd1;
      end
    end
    return ~acc[7:0];
  endfunction

  function automatic logic [63:0] low_bytes(input logic [63:0] bytes, input int n);
    logic [63:0] res;
    int i;
    res = '0;
    for (i = 0; i < n && i < MAX_BYTES_DEF; i++) begin
      res[8*i +: 8] = bytes[8*i +: 8];
    end
    return res;
  endfunction

  // One accepted item in, one expected reply out; updates the frame state.
  function automatic out_item_t frame_step(input in_item_t it);
    out_item_t r;
    logic send;
    logic [7:0] txb;
    logic bad;
    int i;
    r = '0;
    send = 1'b0;
    txb = 8'h00;
    bad = 1'b0;
    case (it.req_type)
      REQ_TICK: begin
        if (fr_phase != FR_IDLE && fr_age != AGE_MAX) begin
          fr_age = fr_age + 16'd1;
        end
      end
      REQ_START: begin
        // length check comes before the busy check
        if (it.frame_len > MAX_BYTES_DEF) begin
          r.start_status = ST_TOO_LONG;
        end else if (fr_phase != FR_IDLE && fr_age < fr_timeout) begin
          r.start_status = ST_BUSY;
        end else begin
          fr_id = it.frame_id;
          fr_pid = pid_of(it.frame_id);
          fr_len = it.frame_len;
          fr_idx = 4'd0;
          fr_publish = it.send_mode;
          fr_enh = it.enhanced;
          if (it.send_mode) begin
            for (i = 0; i < it.frame_len; i++) begin
              fr_data[8*i +: 8] = it.payload[8*i +: 8];
            end
          end
          fr_age = 16'd0;
          fr_phase = FR_BREAK;
          r.start_status = ST_ACCEPTED;
          r.send_break = 1'b1;
        end
      end
      REQ_RXBYTE: begin
        case (fr_phase)
          FR_BREAK: begin
            if (it.rx_byte == BREAK_BYTE) begin
              send = 1'b1;
              txb = SYNC_BYTE;
              fr_phase = FR_SYNC;
            end else begin
              bad = 1'b1;
            end
          end
          FR_SYNC: begin
            if (it.rx_byte == SYNC_BYTE) begin
              send = 1'b1;
              txb = fr_pid;
              fr_idx = 4'd0;
              fr_phase = FR_PID;
            end else begin
              bad = 1'b1;
            end
          end
          FR_PID: begin
            if (it.rx_byte != fr_pid) begin
              bad = 1'b1;
            end else begin
              fr_idx = 4'd0;
              if (fr_len == 4'd0) begin
                if (fr_publish) begin
                  // empty published frame: checksum goes out on the PID echo
                  fr_chk = checksum_of(fr_enh ? fr_pid : 8'h00, fr_data, fr_len);
                  send = 1'b1;
                  txb = fr_chk;
                  fr_phase = FR_CHECKSUM_ECHO;
                end else begin
                  fr_phase = FR_CHECKSUM;
                end
              end else if (fr_publish) begin
                send = 1'b1;
                txb = fr_data[7:0];
                fr_idx = 4'd1;
                fr_phase = (fr_len == 4'd1) ? FR_CHECKSUM : FR_DATA;
              end else begin
                fr_phase = FR_DATA;
              end
            end
          end
          FR_DATA: begin
            if (fr_idx >= fr_len || fr_idx >= MAX_BYTES_DEF) begin
              fr_phase = FR_CHECKSUM;
            end else begin
              // data echoes are not compared
              if (fr_publish) begin
                send = 1'b1;
                txb = fr_data[8*fr_idx +: 8];
              end else begin
                fr_data[8*fr_idx +: 8] = it.rx_byte;
              end
              fr_idx = fr_idx + 4'd1;
              if (fr_idx >= fr_len) begin
                fr_phase = FR_CHECKSUM;
              end
            end
          end
          FR_CHECKSUM: begin
            fr_chk = checksum_of(fr_enh ? fr_pid : 8'h00, fr_data, fr_len);
            if (fr_publish) begin
              send = 1'b1;
              txb = fr_chk;
              fr_phase = FR_CHECKSUM_ECHO;
            end else if (it.rx_byte == fr_chk) begin
              r.frame_done = DONE_RECEIVED;
              r.rx_frame_id = fr_id;
              r.rx_frame_len = fr_len;
              r.rx_payload = low_bytes(fr_data, fr_len);
              fr_phase = FR_IDLE;
            end else begin
              bad = 1'b1;
            end
          end
          FR_CHECKSUM_ECHO: begin
            if (it.rx_byte == fr_chk) begin
              r.frame_done = DONE_SENT;
              fr_phase = FR_IDLE;
            end else begin
              bad = 1'b1;
            end
          end
          default: begin
            fr_phase = FR_IDLE;
          end
        endcase
        if (bad) begin
          r.frame_done = DONE_ERROR;
          fr_phase = FR_IDLE;
        end
      end
      default: ;
    endcase
    if (send) begin
      r.tx_valid = 1'b1;
      r.tx_byte = txb;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Unused fields carry random junk so the engine must ignore them.
  function automatic in_item_t junk_item(input logic [1:0] code);
    in_item_t it;
    it.req_type = code;
    it.frame_id = 6'($urandom_range(0, 63));
    it.frame_len = 4'($urandom_range(0, 15));
    it.send_mode = 1'($urandom_range(0, 1));
    it.enhanced = 1'($urandom_range(0, 1));
    it.payload = {$urandom, $urandom};
    it.rx_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic void push_item(input in_item_t it);
    pending_items.push_back(it);
    issued_count++;
  endfunction

  function automatic void push_tick();
    push_item(junk_item(REQ_TICK));
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    in_item_t it;
    it = junk_item(REQ_RXBYTE);
    it.rx_byte = b;
    push_item(it);
  endfunction

  function automatic void push_start(input logic [5:0] id, input logic [3:0] len,
                                     input logic mode, input logic enh,
                                     input logic [63:0] pl);
    in_item_t it;
    it = junk_item(REQ_START);
    it.frame_id = id;
    it.frame_len = len;
    it.send_mode = mode;
    it.enhanced = enh;
    it.payload = pl;
    push_item(it);
  endfunction

  // Mostly complete frames with random content; some corrupted or cut short,
  // plus tick bursts, oversized starts and noise.
  task automatic queue_traffic(input int n);
    int made;
    int pick;
    int n_bytes;
    int stop;
    int p;
    int k;
    int cap;
    logic [5:0] id;
    logic [3:0] len;
    logic mode;
    logic enh;
    logic [63:0] pl;
    logic [63:0] data;
    logic [7:0] pid;
    logic [7:0] seq [12];
    made = 0;
    cap = (timeout_now + 2 > 40) ? 40 : timeout_now + 2;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        id = 6'($urandom_range(0, 63));
        len = 4'($urandom_range(0, MAX_BYTES_DEF));
        mode = 1'($urandom_range(0, 1));
        enh = 1'($urandom_range(0, 1));
        pl = {$urandom, $urandom};
        pid = pid_of(id);
        data = mode ? pl : {$urandom, $urandom};
        n_bytes = len + 4;
        seq[0] = BREAK_BYTE;
        seq[1] = SYNC_BYTE;
        seq[2] = pid;
        for (k = 0; k < len; k++) begin
          seq[3 + k] = data[8*k +: 8];
        end
        seq[3 + len] = checksum_of(enh ? pid : 8'h00, data, len);
        stop = n_bytes;
        if ($urandom_range(0, 99) < 25) begin
          p = $urandom_range(0, n_bytes - 1);
          if ($urandom_range(0, 1) == 0) begin
            seq[p] = seq[p] ^ 8'($urandom_range(1, 255));
          end else begin
            stop = p;
          end
        end
        push_start(id, len, mode, enh, pl);
        made++;
        for (k = 0; k < stop; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            push_tick();
            made++;
          end
          push_byte(seq[k]);
          made++;
        end
      end else if (pick < 84) begin
        k = $urandom_range(1, cap);
        repeat (k) push_tick();
        made += k;
      end else if (pick < 92) begin
        push_start(6'($urandom_range(0, 63)), 4'($urandom_range(9, 15)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), {$urandom, $urandom});
        made++;
      end else begin
        push_item(junk_item(2'($urandom_range(0, 3))));
        made++;
      end
    end
  endtask

  task automatic write_timeout(input logic [15:0] v);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    fr_timeout = v;
    timeout_now = v;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Every item yields one reply; wait for all of them, then let the pipe settle.
  task automatic drain();
    wait (checked_count == issued_count);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // Request driver: new item at the falling edge once the last one was taken.
  always @(negedge clk) begin
    if (!rst && (!req_bus.valid || req_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        next_req = pending_items.pop_front();
        req_bus.valid <= 1'b1;
        req_bus.req_type <= next_req.req_type;
        req_bus.frame_id <= next_req.frame_id;
        req_bus.frame_len <= next_req.frame_len;
        req_bus.send_mode <= next_req.send_mode;
        req_bus.enhanced <= next_req.enhanced;
        req_bus.payload <= next_req.payload;
        req_bus.rx_byte <= next_req.rx_byte;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // Reply back-pressure, with an occasional long hold-off to fill the engine.
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Monitor: predict on request accept, compare on reply accept.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst) begin
      fr_phase = FR_IDLE;
      fr_publish = 1'b0;
      fr_enh = 1'b0;
      fr_id = '0;
      fr_pid = '0;
      fr_data = '0;
      fr_len = '0;
      fr_idx = '0;
      fr_chk = '0;
      fr_age = '0;
      fr_timeout = TIMEOUT_RESET;
    end else begin
      if (req_bus.valid && !req_bus.ready) begin
        n_in_stalls++;
      end
      if (req_bus.valid && req_bus.ready) begin
        seen_req.req_type = req_bus.req_type;
        seen_req.frame_id = req_bus.frame_id;
        seen_req.frame_len = req_bus.frame_len;
        seen_req.send_mode = req_bus.send_mode;
        seen_req.enhanced = req_bus.enhanced;
        seen_req.payload = req_bus.payload;
        seen_req.rx_byte = req_bus.rx_byte;
        want_rsp = frame_step(seen_req);
        expected_replies.push_back(want_rsp);
        req_taken = 1'b1;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        seen_rsp.start_status = rsp_bus.start_status;
        seen_rsp.send_break = rsp_bus.send_break;
        seen_rsp.tx_valid = rsp_bus.tx_valid;
        seen_rsp.tx_byte = rsp_bus.tx_byte;
        seen_rsp.frame_done = rsp_bus.frame_done;
        seen_rsp.rx_frame_id = rsp_bus.rx_frame_id;
        seen_rsp.rx_frame_len = rsp_bus.rx_frame_len;
        seen_rsp.rx_payload = rsp_bus.rx_payload;
        if (expected_replies.size() == 0) begin
          $error("reply item with no expectation pending");
          mismatches++;
        end else begin
          want_rsp = expected_replies.pop_front();
          check_field("start_status", want_rsp.start_status, seen_rsp.start_status);
          check_field("send_break", want_rsp.send_break, seen_rsp.send_break);
          check_field("tx_valid", want_rsp.tx_valid, seen_rsp.tx_valid);
          check_field("tx_byte", want_rsp.tx_byte, seen_rsp.tx_byte);
          check_field("frame_done", want_rsp.frame_done, seen_rsp.frame_done);
          check_field("rx_frame_id", want_rsp.rx_frame_id, seen_rsp.rx_frame_id);
          check_field("rx_frame_len", want_rsp.rx_frame_len, seen_rsp.rx_frame_len);
          check_field("rx_payload", want_rsp.rx_payload, seen_rsp.rx_payload);
          case (want_rsp.frame_done)
            DONE_SENT:     n_sent++;
            DONE_RECEIVED: n_recv++;
            DONE_ERROR:    n_err++;
            default: ;
          endcase
          if (want_rsp.start_status == ST_ACCEPTED) begin
            n_accept++;
          end else if (want_rsp.start_status != ST_NONE) begin
            n_refused++;
          end
          checked_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_TICK;
    req_bus.frame_id = '0;
    req_bus.frame_len = '0;
    req_bus.send_mode = 1'b0;
    req_bus.enhanced = 1'b0;
    req_bus.payload = '0;
    req_bus.rx_byte = '0;
    rsp_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    set_idling(0, 0);
    timeout_now = TIMEOUT_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: short timeout so that abandoning a frame takes three ticks.
    write_timeout(16'd3);
    push_byte(BREAK_BYTE);                            // byte with no frame: ignored
    push_tick();                                      // tick with no frame: age stays
    push_item(junk_item(REQ_UNUSED));                 // unused code: all zero
    push_start(6'h15, 4'd9, 1'b1, 1'b0, {$urandom, $urandom});  // too long
    // one-byte published frame, enhanced, all ones; a second start is busy
    push_start(6'h3F, 4'd1, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    push_start(6'h01, 4'd2, 1'b0, 1'b0, 64'h0);
    push_byte(BREAK_BYTE);
    push_byte(SYNC_BYTE);
    push_byte(pid_of(6'h3F));
    push_byte(8'hFF);                                 // data echo: checksum goes out
    push_byte(checksum_of(pid_of(6'h3F), 64'hFF, 1));
    // empty subscribed frame, classic: next byte after PID is the checksum
    push_start(6'h00, 4'd0, 1'b0, 1'b0, 64'h0);
    push_byte(BREAK_BYTE);
    push_byte(SYNC_BYTE);
    push_byte(pid_of(6'h00));
    push_byte(checksum_of(8'h00, 64'h0, 0));
    // empty published frame: checksum sent on the PID echo
    push_start(6'h2A, 4'd0, 1'b1, 1'b0, 64'h0);
    push_byte(BREAK_BYTE);
    push_byte(SYNC_BYTE);
    push_byte(pid_of(6'h2A));
    push_byte(checksum_of(8'h00, 64'h0, 0));
    // stale frame abandoned after the timeout, then a bad break echo
    push_start(6'h11, 4'd2, 1'b1, 1'b1, 64'hA55A);
    repeat (3) push_tick();
    push_start(6'h22, 4'd8, 1'b0, 1'b1, 64'h0);
    push_byte(8'h01);
    drain();

    // Random phases, each with its own timeout and idling mix.
    write_timeout(16'd1);
    set_idling(0, 0);
    queue_traffic(RANDOM_ITEMS);
    hold_asks++;                                      // long reply stall, input backs up
    drain();

    write_timeout(16'd9);
    set_idling(48, 0);
    queue_traffic(RANDOM_ITEMS);
    drain();

    write_timeout(16'd40);
    set_idling(0, 48);
    queue_traffic(RANDOM_ITEMS);
    drain();

    write_timeout(TIMEOUT_RESET);
    set_idling(26, 26);
    queue_traffic(RANDOM_ITEMS);
    drain();

    if (expected_replies.size() != 0) begin
      $error("%0d expected replies never arrived", expected_replies.size());
      mismatches++;
    end
    $display("Run covered %0d replies: %0d frames sent, %0d received, %0d ended in error.",
             checked_count, n_sent, n_recv, n_err);
    $display("Starts accepted %0d, refused %0d; request side held off %0d cycles.",
             n_accept, n_refused, n_in_stalls);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
